/* rtl/core/wsd_pkg.sv */
package wsd_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  // length codes that bring an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // extended length sizes in bytes
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // padded width of the result tdata
  localparam int RES_TDATA_W = 24;

  // one result beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       final_fragment;
    logic [2:0] reserved_bits;
    logic [3:0] frame_opcode;
    logic       was_masked;
    logic       last_in_frame;
  } result_t;

endpackage

/* rtl/core/wsd_parser.sv */
module wsd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [7:0]       in_byte,
  output logic             res_valid,
  output wsd_pkg::result_t res
);

  wsd_pkg::phase_t phase, phase_next;
  logic [7:0]  flags, flags_next;
  logic        mask, mask_next;
  logic [3:0]  ext_left, ext_left_next;
  logic [63:0] rem, rem_next;
  logic [31:0] key, key_next;
  logic [1:0]  kidx, kidx_next;

  logic       emit;
  logic       emit_has;
  logic       emit_last;
  logic [7:0] emit_data;
  logic       len_done;
  logic       start;
  logic [7:0] key_byte;

  // key byte for the current payload position, most significant first
  always_comb begin
    case (kidx)
      2'd0:    key_byte = key[31:24];
      2'd1:    key_byte = key[23:16];
      2'd2:    key_byte = key[15:8];
      default: key_byte = key[7:0];
    endcase
  end

  // next state and result
  always_comb begin
    phase_next    = phase;
    flags_next    = flags;
    mask_next     = mask;
    ext_left_next = ext_left;
    rem_next      = rem;
    key_next      = key;
    kidx_next     = kidx;
    emit          = 1'b0;
    emit_has      = 1'b0;
    emit_last     = 1'b0;
    emit_data     = 8'd0;
    len_done      = 1'b0;
    start         = 1'b0;

    case (phase)
      wsd_pkg::PH_HDR1: begin
        mask_next = in_byte[7];
        rem_next  = 64'd0;
        kidx_next = 2'd0;
        key_next  = 32'd0;
        if (in_byte[6:0] == wsd_pkg::LEN_EXT16) begin
          ext_left_next = wsd_pkg::EXT16_BYTES;
          phase_next    = wsd_pkg::PH_EXT;
        end else if (in_byte[6:0] == wsd_pkg::LEN_EXT64) begin
          ext_left_next = wsd_pkg::EXT64_BYTES;
          phase_next    = wsd_pkg::PH_EXT;
        end else begin
          rem_next = {57'd0, in_byte[6:0]};
          len_done = 1'b1;
        end
      end
      wsd_pkg::PH_EXT: begin
        rem_next      = {rem[55:0], in_byte};
        ext_left_next = ext_left - 4'd1;
        if (ext_left_next == 4'd0) begin
          len_done = 1'b1;
        end
      end
      wsd_pkg::PH_KEY: begin
        key_next  = {key[23:0], in_byte};
        kidx_next = kidx + 2'd1;
        if (kidx_next == 2'd0) begin
          start = 1'b1;
        end
      end
      wsd_pkg::PH_DATA: begin
        emit      = 1'b1;
        emit_has  = 1'b1;
        emit_data = mask ? (in_byte ^ key_byte) : in_byte;
        kidx_next = kidx + 2'd1;
        rem_next  = rem - 64'd1;
        emit_last = (rem == 64'd1);
        if (emit_last) begin
          phase_next = wsd_pkg::PH_HDR0;
        end
      end
      default: begin
        flags_next = in_byte;
        phase_next = wsd_pkg::PH_HDR1;
      end
    endcase

    // length known: key follows or payload starts
    if (len_done) begin
      if (mask_next) begin
        phase_next = wsd_pkg::PH_KEY;
        kidx_next  = 2'd0;
        key_next   = 32'd0;
      end else begin
        start = 1'b1;
      end
    end

    // header complete: empty frame marker or payload
    if (start) begin
      kidx_next = 2'd0;
      if (rem_next == 64'd0) begin
        phase_next = wsd_pkg::PH_HDR0;
        emit       = 1'b1;
        emit_last  = 1'b1;
      end else begin
        phase_next = wsd_pkg::PH_DATA;
      end
    end
  end

  // result fields
  always_comb begin
    res_valid          = in_valid && emit;
    res.data_byte      = emit_data;
    res.has_data       = emit_has;
    res.final_fragment = flags[7];
    res.reserved_bits  = flags[6:4];
    res.frame_opcode   = flags[3:0];
    res.was_masked     = mask_next;
    res.last_in_frame  = emit_last;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= wsd_pkg::PH_HDR0;
      flags    <= 8'd0;
      mask     <= 1'b0;
      ext_left <= 4'd0;
      rem      <= 64'd0;
      key      <= 32'd0;
      kidx     <= 2'd0;
    end else if (in_valid) begin
      phase    <= phase_next;
      flags    <= flags_next;
      mask     <= mask_next;
      ext_left <= ext_left_next;
      rem      <= rem_next;
      key      <= key_next;
      kidx     <= kidx_next;
    end
  end

  // an empty-frame marker always closes its frame
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.has_data |-> res.last_in_frame)
    else $error("empty frame marker without last flag");

  // payload phase never runs with nothing left
  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == wsd_pkg::PH_DATA |-> rem != 64'd0)
    else $error("payload phase with zero count");

  // extended length phase always has bytes to collect
  a_ext_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == wsd_pkg::PH_EXT |-> ext_left != 4'd0)
    else $error("extended length phase with no bytes left");

  // key collection only for masked frames
  a_key_masked: assert property (@(posedge clk) disable iff (rst)
    phase == wsd_pkg::PH_KEY |-> mask)
    else $error("key phase on unmasked frame");

  // the last payload beat returns to header parsing
  a_last_to_hdr: assert property (@(posedge clk) disable iff (rst)
    in_valid && phase == wsd_pkg::PH_DATA && rem == 64'd1 |=> phase == wsd_pkg::PH_HDR0)
    else $error("frame end did not return to header");

endmodule

/* rtl/core/websocket_frame_deframer_core.sv */
// WebSocket frame deframer with payload unmasking.
// Input stream s_axis_*: one raw byte per beat, header and payload bytes
// back to back as they arrive from the connection.
// Output stream m_axis_*: one beat per payload byte, unmasked, with the
// header fields of its frame; a frame of length zero gives one beat with
// tuser low. tlast marks the final beat of each frame.
// Header, extended-length and mask-key bytes are absorbed and give no beat,
// except the byte that completes the header of an empty frame.
// Throughput: one byte per cycle unless m_axis stalls. A result appears on
// m_axis in the cycle after its input byte is accepted; the parse state and
// the unmask logic sit between the input handshake and one output register.
// s_axis_tready is high whenever the output register is empty or being
// drained in the same cycle, so a stalled receiver holds the stream after
// one pending beat; nothing is dropped.
// Reset (rst, synchronous) returns the parser to waiting for the first
// header byte of a frame and empties the output register.
module websocket_frame_deframer_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // in_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // data_byte[7:0], final_fragment[8], reserved_bits[11:9],
  // frame_opcode[15:12], was_masked[16], zero fill [23:17]
  output logic [wsd_pkg::RES_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser,  // has_data
  output logic                              m_axis_tlast   // last_in_frame
);

  logic             in_accept;
  logic             res_valid;
  wsd_pkg::result_t res;
  wsd_pkg::result_t out_reg;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_accept),
    .in_byte   (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_axis_tvalid <= res_valid;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      out_reg <= res;
    end
  end

  assign m_axis_tdata = {7'd0, out_reg.was_masked, out_reg.frame_opcode,
                         out_reg.reserved_bits, out_reg.final_fragment,
                         out_reg.data_byte};
  assign m_axis_tuser = out_reg.has_data;
  assign m_axis_tlast = out_reg.last_in_frame;

endmodule
